// ===== hw/rtl/prtp_pkg.sv =====
// shared constants and types for the priority release task picker
package prtp_pkg;

  // table geometry
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CMP_W      = (SLOT_W > 4) ? SLOT_W : 4;

  // action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_PICK   = 2'd2;

  // request transfer payload
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot_index;
    logic [7:0]  task_priority;
    logic        task_runnable;
    logic [31:0] release_time;
    logic [31:0] now_ms;
  } task_req_t;

  // response transfer payload
  typedef struct packed {
    logic       success;
    logic [3:0] slot_out;
  } task_resp_t;

  // token handed from cell to cell during a sweep
  typedef struct packed {
    logic              active;
    task_req_t         req;
    logic              found;
    logic [7:0]        best_prio;
    logic [SLOT_W-1:0] best_idx;
  } sweep_tok_t;

endpackage

// ===== hw/rtl/prtp_cell.sv =====
// one task slot of the table, updating and passing on the sweep token
module prtp_cell
  import prtp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] cell_idx,
  input  sweep_tok_t        tok_in,
  output sweep_tok_t        tok_out
);

  // slot contents
  logic        occupied;
  logic [7:0]  priority_q;
  logic        ready;
  logic [31:0] release_q;

  sweep_tok_t tok_next;
  logic       occupied_next;
  logic       write_slot;
  logic       qualifies;

  // pick eligibility of this slot
  assign qualifies = occupied && ready && (tok_in.req.now_ms >= release_q);

  // per-slot handling of the passing token
  always_comb begin
    tok_next      = tok_in;
    occupied_next = occupied;
    write_slot    = 1'b0;
    if (tok_in.active) begin
      unique case (tok_in.req.action)
        ACT_ADD: begin
          if (!tok_in.found && !occupied) begin
            occupied_next     = 1'b1;
            write_slot        = 1'b1;
            tok_next.found    = 1'b1;
            tok_next.best_idx = cell_idx;
          end
        end
        ACT_REMOVE: begin
          if (CMP_W'(tok_in.req.slot_index) == CMP_W'(cell_idx)) begin
            occupied_next = 1'b0;
          end
        end
        ACT_PICK: begin
          if (qualifies && (!tok_in.found || priority_q > tok_in.best_prio)) begin
            tok_next.found     = 1'b1;
            tok_next.best_prio = priority_q;
            tok_next.best_idx  = cell_idx;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  // control state, token payload and slot data
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied       <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      occupied       <= occupied_next;
      tok_out.active <= tok_next.active;
    end
    tok_out.req       <= tok_next.req;
    tok_out.found     <= tok_next.found;
    tok_out.best_prio <= tok_next.best_prio;
    tok_out.best_idx  <= tok_next.best_idx;
    if (write_slot) begin
      priority_q <= tok_in.req.task_priority;
      ready      <= tok_in.req.task_runnable;
      release_q  <= tok_in.req.release_time;
    end
  end

endmodule

// ===== hw/rtl/priority_release_task_picker.sv =====
// top level of the priority release task picker: request intake, cell row, response register
//
// Each request (add, remove or pick) is handled by a token that walks a row of TASK_SLOTS slot
// cells, one cell per clock, after an entry register, and the last cell feeds the response
// register. One request is in flight at a time, so no new request is taken while a token is
// in the row. A new request is taken once the previous response has left the response
// register or leaves it in the same cycle. Occupancy marks clear on reset; slot data is
// written only by add. Add takes the lowest free slot, pick returns the runnable, released
// slot of highest priority (lowest index on a tie), and every request gets exactly one
// response.
module priority_release_task_picker
  import prtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  task_req_t  req,
  output logic       resp_valid,
  input  logic       resp_stall,
  output task_resp_t resp
);

  sweep_tok_t            tok [TASK_SLOTS+1];
  logic [TASK_SLOTS:0]   tok_active;
  logic                  busy;
  logic                  req_xfer;
  logic                  last_active;
  task_resp_t            resp_next;

  // intake handshake
  assign req_stall   = busy || (resp_valid && resp_stall);
  assign req_xfer    = req_valid && !req_stall;
  assign last_active = tok[TASK_SLOTS].active;

  // token entering the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].active <= 1'b0;
    end else begin
      tok[0].active <= req_xfer;
    end
    tok[0].req       <= req;
    tok[0].found     <= 1'b0;
    tok[0].best_prio <= 8'd0;
    tok[0].best_idx  <= '0;
  end

  // row of slot cells
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    prtp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (SLOT_W'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  for (genvar i = 0; i <= TASK_SLOTS; i++) begin : g_act
    assign tok_active[i] = tok[i].active;
  end

  // response from the finished token
  always_comb begin
    resp_next.success  = 1'b0;
    resp_next.slot_out = 4'd0;
    unique case (tok[TASK_SLOTS].req.action)
      ACT_ADD, ACT_PICK: begin
        resp_next.success  = tok[TASK_SLOTS].found;
        resp_next.slot_out = tok[TASK_SLOTS].found ? 4'(tok[TASK_SLOTS].best_idx) : 4'd0;
      end
      ACT_REMOVE: begin
        resp_next.success = 1'b1;
      end
      default: begin
        resp_next.success = 1'b0;
      end
    endcase
  end

  // busy flag and response register control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      if (req_xfer) begin
        busy <= 1'b1;
      end else if (last_active) begin
        busy <= 1'b0;
      end
      if (last_active) begin
        resp_valid <= 1'b1;
      end else if (resp_valid && !resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_active) begin
      resp <= resp_next;
    end
  end

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_active) <= 1)
    else $error("more than one token in the cell row");

  a_token_while_busy: assert property (@(posedge clk) disable iff (rst)
    last_active |-> busy)
    else $error("token finished without a request in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    last_active |-> !resp_valid)
    else $error("response register still full when a result arrives");

  a_slot_implies_success: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && resp.slot_out != 4'd0) |-> resp.success)
    else $error("slot reported without success");

endmodule

// ===== dv/priority_release_task_picker_tb.sv =====
// testbench for the priority release task picker: directed and random traffic, checked per reply
`timescale 1ns / 1ps

module priority_release_task_picker_tb;
  import prtp_pkg::*;

  // spare action code, must be ignored by the block
  localparam logic [1:0] ACT_SPARE    = 2'd3;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         MAX_REPORTS  = 10;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       req_valid  = 1'b0;
  task_req_t  req        = '0;
  logic       resp_stall = 1'b0;
  logic       req_stall;
  logic       resp_valid;
  task_resp_t resp;

  int         idle_pct   = 0;
  int         stall_pct  = 0;
  int         mismatches = 0;
  logic [31:0] epoch     = '0;

  // replies owed by the block, oldest first
  task_resp_t replies_due[$];

  // shadow copy of the task table
  bit          slot_busy    [TASK_SLOTS];
  logic [7:0]  slot_prio    [TASK_SLOTS];
  bit          slot_ready   [TASK_SLOTS];
  logic [31:0] slot_release [TASK_SLOTS];

  priority_release_task_picker i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

  always #5 clk = ~clk;

  // apply one request to the shadow table and work out the reply it earns
  function automatic task_resp_t table_reply(input task_req_t r);
    task_resp_t rep;
    bit         found;
    int         best;
    rep   = '0;
    found = 1'b0;
    best  = 0;
    case (r.action)
      ACT_ADD: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!found && !slot_busy[i]) begin
            found           = 1'b1;
            slot_busy[i]    = 1'b1;
            slot_prio[i]    = r.task_priority;
            slot_ready[i]   = r.task_runnable;
            slot_release[i] = r.release_time;
            rep.success     = 1'b1;
            rep.slot_out    = 4'(i);
          end
        end
      end
      ACT_REMOVE: begin
        if (int'(r.slot_index) < TASK_SLOTS) slot_busy[r.slot_index] = 1'b0;
        rep.success = 1'b1;
      end
      ACT_PICK: begin
        // strict greater-than keeps the lowest index on a tie
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (slot_busy[i] && slot_ready[i] && r.now_ms >= slot_release[i]) begin
            if (!found || slot_prio[i] > slot_prio[best]) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        rep.success  = found;
        rep.slot_out = found ? 4'(best) : 4'd0;
      end
      default: ;
    endcase
    return rep;
  endfunction

  // time stamps clustered round the phase epoch so release and now often meet
  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return '1;
      8, 9:    return $urandom;
      default: return epoch + 32'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input task_resp_t want, input task_resp_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected success %0b slot %0d, got success %0b slot %0d",
               $time, what, want.success, want.slot_out, got.success, got.slot_out);
  endtask

  // one request transfer, with random idle cycles ahead of it
  task automatic send_req(input task_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    replies_due.push_back(table_reply(r));
  endtask

  task automatic post_task(input logic [7:0] prio, input logic run, input logic [31:0] rel);
    task_req_t r;
    r               = '0;
    r.action        = ACT_ADD;
    r.task_priority = prio;
    r.task_runnable = run;
    r.release_time  = rel;
    send_req(r);
  endtask

  task automatic remove_slot(input logic [3:0] idx);
    task_req_t r;
    r            = '0;
    r.action     = ACT_REMOVE;
    r.slot_index = idx;
    send_req(r);
  endtask

  task automatic pick_at(input logic [31:0] now);
    task_req_t r;
    r        = '0;
    r.action = ACT_PICK;
    r.now_ms = now;
    send_req(r);
  endtask

  // empty table: pick finds nothing, remove of a free slot, spare action code
  task automatic check_empty_table();
    task_req_t r;
    pick_at('1);
    remove_slot(4'd7);
    r        = '1;
    r.action = ACT_SPARE;
    send_req(r);
  endtask

  // fill every slot with varied tasks, then one add into a full table
  task automatic check_fill_until_full();
    post_task(8'd0,   1'b1, 32'd0);
    post_task(8'd255, 1'b0, 32'd0);
    post_task(8'd255, 1'b1, '1);
    post_task(8'd200, 1'b1, 32'd1000);
    post_task(8'd200, 1'b1, 32'd1000);
    for (int i = 5; i < TASK_SLOTS; i++)
      post_task(8'(i), 1'b1, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
    post_task(8'd99, 1'b1, 32'd0);
  endtask

  // release boundaries, priority ties and pick after a remove
  task automatic check_pick_priority();
    pick_at(32'd0);
    pick_at(32'd1000);
    pick_at('1);
    remove_slot(4'd2);
    pick_at('1);
  endtask

  // mostly well-formed traffic with removes aimed at live slots
  task automatic run_random_traffic(input int count, input int idle, input int stall);
    task_req_t r;
    int        roll;
    int        start;
    bit        hit;
    idle_pct  = idle;
    stall_pct = stall;
    epoch     = $urandom;
    repeat (count) begin
      r.slot_index    = 4'($urandom);
      r.task_priority = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r.task_runnable = ($urandom_range(0, 3) != 0);
      r.release_time  = rand_stamp();
      r.now_ms        = rand_stamp();
      roll = $urandom_range(0, 99);
      if (roll < 35)      r.action = ACT_ADD;
      else if (roll < 60) r.action = ACT_REMOVE;
      else if (roll < 95) r.action = ACT_PICK;
      else                r.action = ACT_SPARE;
      if (r.action == ACT_REMOVE && $urandom_range(0, 99) < 80) begin
        start = int'(r.slot_index);
        hit   = 1'b0;
        for (int k = 0; k < TASK_SLOTS; k++) begin
          if (!hit && slot_busy[(start + k) % TASK_SLOTS]) begin
            hit          = 1'b1;
            r.slot_index = 4'((start + k) % TASK_SLOTS);
          end
        end
      end
      send_req(r);
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    resp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // reply checker
  always @(posedge clk) begin
    task_resp_t want;
    if (!rst && resp_valid && !resp_stall) begin
      if (replies_due.size() == 0) begin
        note_mismatch("reply with none due", '0, resp);
      end else begin
        want = replies_due.pop_front();
        if (resp.success !== want.success || resp.slot_out !== want.slot_out)
          note_mismatch("reply mismatch", want, resp);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_empty_table();
    check_fill_until_full();
    check_pick_priority();
    run_random_traffic(250, 0, 0);
    run_random_traffic(250, 53, 0);
    run_random_traffic(250, 0, 53);
    run_random_traffic(250, 20, 20);
    @(negedge clk);
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("priority_release_task_picker_tb OK");
    end else begin
      $display("priority_release_task_picker_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("priority_release_task_picker_tb NOT OK");
    $finish;
  end

endmodule
